/* design/assert_macros.svh */
// assert_macros.svh: concurrent assertion macros for the line rasterizer RTL.
// Expects clk and rst_n (synchronous, active low) in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lri_pkg.sv */
// lri_pkg: shared types and constants of the line rasterizer with color interpolation.
// No dependencies; used by lri_walk, lri_color and the top level.
`default_nettype none

package lri_pkg;

  localparam int COLOR_W   = 32;
  localparam int CH_BITS   = 8;
  localparam int NUM_CH    = COLOR_W / CH_BITS;
  localparam int CH_IDX_W  = 2;
  localparam int DIV_STEPS = CH_BITS / 2;  // two quotient bits per cycle
  localparam int DIV_CNT_W = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic load;  // latch raw endpoints
    logic prep;  // set up the walk from latched endpoints
    logic step;  // advance one pixel
  } walk_ctl_t;

  typedef struct packed {
    logic start;
    logic ack;
  } color_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } color_sts_t;

endpackage

`default_nettype wire

/* design/lri_walk.sv */
// lri_walk: line setup and pixel walker (axis-aligned walk and Bresenham walk).
// Holds endpoints and colors for the color unit. Depends on lri_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lri_walk #(
  parameter int COORD_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lri_pkg::walk_ctl_t                    ctl,
  input  logic signed [COORD_BITS-1:0]          ld_x0,
  input  logic signed [COORD_BITS-1:0]          ld_y0,
  input  logic signed [COORD_BITS-1:0]          ld_x1,
  input  logic signed [COORD_BITS-1:0]          ld_y1,
  input  logic        [lri_pkg::COLOR_W-1:0]    ld_c0,
  input  logic        [lri_pkg::COLOR_W-1:0]    ld_c1,
  output logic                                  active,
  output logic signed [COORD_BITS-1:0]          pix_x,
  output logic signed [COORD_BITS-1:0]          pix_y,
  output logic                                  pix_last,
  output logic                                  swapped,
  output logic signed [COORD_BITS-1:0]          ref_coord,
  output logic signed [COORD_BITS:0]            den,
  output logic        [lri_pkg::COLOR_W-1:0]    col_a,
  output logic        [lri_pkg::COLOR_W-1:0]    col_b
);

  localparam int N = COORD_BITS;
  localparam int W = COORD_BITS + 1;
  localparam int D = COORD_BITS + 3;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_AXIS = 3'b010,
    MODE_BRES = 3'b100
  } mode_t;

  mode_t mode_r, mode_nxt;
  logic  pend_r, pend_nxt;

  logic signed [N-1:0] rx0_r, ry0_r, rx1_r, ry1_r;
  logic [lri_pkg::COLOR_W-1:0] rc0_r, rc1_r;

  logic signed [W-1:0] major_r, major_nxt, minor_r, minor_nxt;
  logic signed [D-1:0] dec_r, dec_nxt, inc_a_r, inc_a_nxt, inc_b_r, inc_b_nxt;
  logic [N-1:0]        steps_r, steps_nxt;
  logic                swap_r, swap_nxt, flip_r, flip_nxt;
  logic signed [N-1:0] ref_r, ref_nxt;
  logic signed [W-1:0] den_r, den_nxt;
  logic [lri_pkg::COLOR_W-1:0] ca_r, ca_nxt, cb_r, cb_nxt;
  logic signed [N-1:0] px_r, px_nxt, py_r, py_nxt;
  logic                last_r, last_nxt;

  // setup terms
  logic signed [W-1:0] x0e, y0e, x1e, y1e;
  logic                vert, horiz, asw;
  logic signed [W-1:0] ax, ay, bx, by, a_major, a_minor, a_len;
  logic                bsw, bflip, bswap;
  logic signed [W-1:0] sx, sy, ex, ey, sy2, ey2, ddx, ddy, dmaj, dmin;
  logic signed [D-1:0] dmaj_d, dmin_d;

  // walk terms
  logic                ge;
  logic signed [W-1:0] e_maj, e_min, ox, oy0, oy;

  always_comb begin
    x0e = {rx0_r[N-1], rx0_r};
    y0e = {ry0_r[N-1], ry0_r};
    x1e = {rx1_r[N-1], rx1_r};
    y1e = {ry1_r[N-1], ry1_r};

    vert  = (rx0_r == rx1_r);
    horiz = (ry0_r == ry1_r);

    // axis-aligned: endpoint a is the lower one along the walked axis
    asw     = vert ? (y0e > y1e) : (x0e > x1e);
    ax      = asw ? x1e : x0e;
    ay      = asw ? y1e : y0e;
    bx      = asw ? x0e : x1e;
    by      = asw ? y0e : y1e;
    a_major = vert ? ay : ax;
    a_minor = vert ? ax : ay;
    a_len   = vert ? (by - ay) : (bx - ax);

    // Bresenham: x-sort, mirror y if falling, swap axes if steep
    bsw   = (x0e > x1e);
    sx    = bsw ? x1e : x0e;
    sy    = bsw ? y1e : y0e;
    ex    = bsw ? x0e : x1e;
    ey    = bsw ? y0e : y1e;
    bflip = (sy > ey);
    sy2   = bflip ? -sy : sy;
    ey2   = bflip ? -ey : ey;
    ddx   = ex - sx;
    ddy   = ey2 - sy2;
    bswap = (ddx < ddy);
    dmaj  = bswap ? ddy : ddx;
    dmin  = bswap ? ddx : ddy;
    dmaj_d = {{(D-W){dmaj[W-1]}}, dmaj};
    dmin_d = {{(D-W){dmin[W-1]}}, dmin};
  end

  always_comb begin
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    dec_nxt   = dec_r;
    inc_a_nxt = inc_a_r;
    inc_b_nxt = inc_b_r;
    steps_nxt = steps_r;
    swap_nxt  = swap_r;
    flip_nxt  = flip_r;
    ref_nxt   = ref_r;
    den_nxt   = den_r;
    ca_nxt    = ca_r;
    cb_nxt    = cb_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    last_nxt  = last_r;

    ge    = !dec_r[D-1];
    e_maj = major_r;
    e_min = minor_r;

    if (ctl.prep) begin
      pend_nxt  = 1'b0;
      if (vert || horiz) begin
        major_nxt = a_major;
        minor_nxt = a_minor;
        steps_nxt = a_len[N-1:0];
        swap_nxt  = vert;
        flip_nxt  = 1'b0;
        ref_nxt   = a_major[N-1:0];
        den_nxt   = a_len;
        ca_nxt    = asw ? rc1_r : rc0_r;
        cb_nxt    = asw ? rc0_r : rc1_r;
        dec_nxt   = '0;
        mode_nxt  = (a_len != '0) ? MODE_AXIS : MODE_IDLE;
      end else begin
        major_nxt = bswap ? sy2 : sx;
        minor_nxt = bswap ? sx : sy2;
        steps_nxt = dmaj[N-1:0];
        swap_nxt  = bswap;
        flip_nxt  = bflip;
        ref_nxt   = bswap ? ry0_r : rx0_r;
        den_nxt   = bswap ? (y1e - y0e) : (x1e - x0e);
        ca_nxt    = rc0_r;
        cb_nxt    = rc1_r;
        dec_nxt   = (dmin_d <<< 1) - dmaj_d;
        inc_a_nxt = dmin_d <<< 1;
        inc_b_nxt = (dmin_d - dmaj_d) <<< 1;
        pend_nxt  = 1'b1;
        mode_nxt  = MODE_BRES;
      end
    end else if (ctl.step) begin
      case (mode_r)
        MODE_AXIS: begin
          last_nxt  = (steps_r == COORD_BITS'(1));
          major_nxt = major_r + W'(1);
          steps_nxt = steps_r - COORD_BITS'(1);
          if (last_nxt) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_BRES: begin
          if (pend_r) begin
            // start pixel: always followed by at least one more
            pend_nxt = 1'b0;
            last_nxt = 1'b0;
          end else begin
            minor_nxt = minor_r + {{(W-1){1'b0}}, ge};
            dec_nxt   = dec_r + (ge ? inc_b_r : inc_a_r);
            major_nxt = major_r + W'(1);
            steps_nxt = steps_r - COORD_BITS'(1);
            last_nxt  = (steps_r == COORD_BITS'(1));
            e_maj     = major_nxt;
            e_min     = minor_nxt;
            if (last_nxt) begin
              mode_nxt = MODE_IDLE;
            end
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
      if (mode_r != MODE_IDLE) begin
        px_nxt = ox[N-1:0];
        py_nxt = oy[N-1:0];
      end
    end
  end

  // map walk coordinates back to screen space
  always_comb begin
    ox  = swap_r ? e_min : e_maj;
    oy0 = swap_r ? e_maj : e_min;
    oy  = flip_r ? -oy0 : oy0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pend_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rx0_r <= ld_x0;
      ry0_r <= ld_y0;
      rx1_r <= ld_x1;
      ry1_r <= ld_y1;
      rc0_r <= ld_c0;
      rc1_r <= ld_c1;
    end
    major_r <= major_nxt;
    minor_r <= minor_nxt;
    dec_r   <= dec_nxt;
    inc_a_r <= inc_a_nxt;
    inc_b_r <= inc_b_nxt;
    steps_r <= steps_nxt;
    swap_r  <= swap_nxt;
    flip_r  <= flip_nxt;
    ref_r   <= ref_nxt;
    den_r   <= den_nxt;
    ca_r    <= ca_nxt;
    cb_r    <= cb_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    last_r  <= last_nxt;
  end

  assign active    = (mode_r != MODE_IDLE);
  assign pix_x     = px_r;
  assign pix_y     = py_r;
  assign pix_last  = last_r;
  assign swapped   = swap_r;
  assign ref_coord = ref_r;
  assign den       = den_r;
  assign col_a     = ca_r;
  assign col_b     = cb_r;

  // an active walk always has pixels left
  `ASSERT_IMP(a_walk_steps, mode_r != MODE_IDLE, steps_r != '0, "active walk with no steps left")

endmodule

`default_nettype wire

/* design/lri_color.sv */
// lri_color: per-pixel color interpolation on one shared multiply / divide unit.
// Four channels in turn: multiply, 2-bit-per-cycle restoring divide, accumulate.
// Depends on lri_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lri_color #(
  parameter int COORD_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lri_pkg::color_ctl_t                ctl,
  output lri_pkg::color_sts_t                sts,
  input  logic signed [COORD_BITS-1:0]       pix_x,
  input  logic signed [COORD_BITS-1:0]       pix_y,
  input  logic                               swapped,
  input  logic signed [COORD_BITS-1:0]       ref_coord,
  input  logic signed [COORD_BITS:0]         den,
  input  logic        [lri_pkg::COLOR_W-1:0] col_a,
  input  logic        [lri_pkg::COLOR_W-1:0] col_b,
  output logic        [lri_pkg::COLOR_W-1:0] color
);

  localparam int N  = COORD_BITS;
  localparam int W  = COORD_BITS + 1;
  localparam int CB = lri_pkg::CH_BITS;
  localparam int P  = COORD_BITS + lri_pkg::CH_BITS;

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_MUL  = 5'b00010,
    C_DIV  = 5'b00100,
    C_ACC  = 5'b01000,
    C_DONE = 5'b10000
  } cstate_t;

  cstate_t st_r, st_nxt;
  logic [lri_pkg::CH_IDX_W-1:0]  ch_r, ch_nxt;
  logic [lri_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  logic signed [W-1:0] num_r, num_nxt;
  logic [N-1:0]        dmag_r, dmag_nxt;
  logic                dneg_r, dneg_nxt;
  logic [P-1:0]        rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [CB-1:0]       quot_r, quot_nxt;
  logic                qneg_r, qneg_nxt;
  logic [lri_pkg::COLOR_W-1:0] color_r, color_nxt;

  logic signed [W-1:0] maj_e, ref_e, den_abs, num_abs;
  logic [CB-1:0]       ca_b, cb_b, q_s;
  logic signed [CB:0]  diff, diff_abs;
  logic [P-1:0]        r1, d2;
  logic                ge1, ge2;

  always_comb begin
    st_nxt    = st_r;
    ch_nxt    = ch_r;
    cnt_nxt   = cnt_r;
    num_nxt   = num_r;
    dmag_nxt  = dmag_r;
    dneg_nxt  = dneg_r;
    rem_nxt   = rem_r;
    dsh_nxt   = dsh_r;
    quot_nxt  = quot_r;
    qneg_nxt  = qneg_r;
    color_nxt = color_r;

    maj_e   = swapped ? {pix_y[N-1], pix_y} : {pix_x[N-1], pix_x};
    ref_e   = {ref_coord[N-1], ref_coord};
    den_abs = den[W-1] ? -den : den;
    num_abs = num_r[W-1] ? -num_r : num_r;

    ca_b     = col_a[ch_r*CB +: CB];
    cb_b     = col_b[ch_r*CB +: CB];
    diff     = {1'b0, cb_b} - {1'b0, ca_b};
    diff_abs = diff[CB] ? -diff : diff;

    ge1 = (rem_r >= dsh_r);
    r1  = ge1 ? (rem_r - dsh_r) : rem_r;
    d2  = dsh_r >> 1;
    ge2 = (r1 >= d2);
    q_s = qneg_r ? -quot_r : quot_r;

    case (st_r)
      C_IDLE: begin
        if (ctl.start) begin
          num_nxt  = maj_e - ref_e;
          dmag_nxt = den_abs[N-1:0];
          dneg_nxt = den[W-1];
          ch_nxt   = '0;
          st_nxt   = C_MUL;
        end
      end
      C_MUL: begin
        rem_nxt  = {{N{1'b0}}, diff_abs[CB-1:0]} * {{CB{1'b0}}, num_abs[N-1:0]};
        qneg_nxt = diff[CB] ^ num_r[W-1] ^ dneg_r;
        dsh_nxt  = {1'b0, dmag_r, {(CB-1){1'b0}}};
        quot_nxt = '0;
        cnt_nxt  = '0;
        st_nxt   = C_DIV;
      end
      C_DIV: begin
        rem_nxt  = ge2 ? (r1 - d2) : r1;
        quot_nxt = {quot_r[CB-3:0], ge1, ge2};
        dsh_nxt  = dsh_r >> 2;
        cnt_nxt  = cnt_r + lri_pkg::DIV_CNT_W'(1);
        if (cnt_r == lri_pkg::DIV_CNT_W'(lri_pkg::DIV_STEPS - 1)) begin
          st_nxt = C_ACC;
        end
      end
      C_ACC: begin
        color_nxt[ch_r*CB +: CB] = ca_b + q_s;
        if (ch_r == lri_pkg::CH_IDX_W'(lri_pkg::NUM_CH - 1)) begin
          st_nxt = C_DONE;
        end else begin
          ch_nxt = ch_r + lri_pkg::CH_IDX_W'(1);
          st_nxt = C_MUL;
        end
      end
      C_DONE: begin
        if (ctl.ack) begin
          st_nxt = C_IDLE;
        end
      end
      default: begin
        st_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r    <= ch_nxt;
    cnt_r   <= cnt_nxt;
    num_r   <= num_nxt;
    dmag_r  <= dmag_nxt;
    dneg_r  <= dneg_nxt;
    rem_r   <= rem_nxt;
    dsh_r   <= dsh_nxt;
    quot_r  <= quot_nxt;
    qneg_r  <= qneg_nxt;
    color_r <= color_nxt;
  end

  assign sts.busy = (st_r != C_IDLE);
  assign sts.done = (st_r == C_DONE);
  assign color    = color_r;

  // after the last quotient bit the remainder is below the divisor
  `ASSERT_IMP(a_div_rem, st_r == C_ACC, rem_r < {{CB{1'b0}}, dmag_r}, "division remainder too large")

endmodule

`default_nettype wire

/* design/line_rasterizer_color_interp_unit.sv */
// Line rasterizer with per-pixel RGBA interpolation: request control and result register.
// Instantiates lri_walk and lri_color. Depends on lri_pkg, assert_macros.svh.
//
//  channel | valid / stall         | payload
//  --------+-----------------------+------------------------------------------------
//  input   | in_valid / in_stall   | cmd, start_x, start_y, end_x, end_y, colors
//  result  | out_valid / out_stall | pixel_x, pixel_y, pixel_color, last
//
// Load request: latch, then line setup; a step request with no line active gives no pixel.
// Step request with a pixel: the walker steps on the accept, a start state launches the shared
// multiply / divide unit for each color channel in turn (multiply, 4 divide steps, accumulate),
// and out_valid rises once the result register is free, in_stall falling in the same cycle.
// rst_n is synchronous; it clears the sequencers and the result valid.
// A waiting result does not block the next request; a finished pixel waits for the
// result register to free up, and in_stall stays high until it has moved there.
`default_nettype none
`include "assert_macros.svh"

module line_rasterizer_color_interp_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic signed [COORD_BITS-1:0]       in_start_x,
  input  logic signed [COORD_BITS-1:0]       in_start_y,
  input  logic signed [COORD_BITS-1:0]       in_end_x,
  input  logic signed [COORD_BITS-1:0]       in_end_y,
  input  logic        [lri_pkg::COLOR_W-1:0] in_start_color,
  input  logic        [lri_pkg::COLOR_W-1:0] in_end_color,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [COORD_BITS-1:0]       out_pixel_x,
  output logic signed [COORD_BITS-1:0]       out_pixel_y,
  output logic        [lri_pkg::COLOR_W-1:0] out_pixel_color,
  output logic                               out_last
);

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_PREP  = 4'b0010,
    T_START = 4'b0100,
    T_CALC  = 4'b1000
  } tstate_t;

  tstate_t st_r, st_nxt;

  lri_pkg::walk_ctl_t  wctl;
  lri_pkg::color_ctl_t cctl;
  lri_pkg::color_sts_t csts;

  logic                        accept, out_free, out_load;
  logic                        w_active, w_last, w_swapped;
  logic signed [COORD_BITS-1:0] w_px, w_py, w_ref;
  logic signed [COORD_BITS:0]  w_den;
  logic [lri_pkg::COLOR_W-1:0] w_ca, w_cb, c_color;

  logic                        out_valid_r, out_valid_nxt;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r;
  logic [lri_pkg::COLOR_W-1:0] out_color_r;
  logic                        out_last_r;

  assign in_stall = (st_r != T_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (st_r == T_CALC) && csts.done && out_free;

  always_comb begin
    wctl.load  = accept && (in_cmd == lri_pkg::CMD_LOAD);
    wctl.step  = accept && (in_cmd == lri_pkg::CMD_STEP);
    wctl.prep  = (st_r == T_PREP);
    cctl.start = (st_r == T_START);
    cctl.ack   = out_load;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      T_IDLE: begin
        if (wctl.load) begin
          st_nxt = T_PREP;
        end else if (wctl.step && w_active) begin
          st_nxt = T_START;
        end
      end
      T_PREP: begin
        st_nxt = T_IDLE;
      end
      T_START: begin
        st_nxt = T_CALC;
      end
      T_CALC: begin
        if (out_load) begin
          st_nxt = T_IDLE;
        end
      end
      default: begin
        st_nxt = T_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r     <= w_px;
      out_y_r     <= w_py;
      out_color_r <= c_color;
      out_last_r  <= w_last;
    end
  end

  lri_walk #(
    .COORD_BITS(COORD_BITS)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (wctl),
    .ld_x0     (in_start_x),
    .ld_y0     (in_start_y),
    .ld_x1     (in_end_x),
    .ld_y1     (in_end_y),
    .ld_c0     (in_start_color),
    .ld_c1     (in_end_color),
    .active    (w_active),
    .pix_x     (w_px),
    .pix_y     (w_py),
    .pix_last  (w_last),
    .swapped   (w_swapped),
    .ref_coord (w_ref),
    .den       (w_den),
    .col_a     (w_ca),
    .col_b     (w_cb)
  );

  lri_color #(
    .COORD_BITS(COORD_BITS)
  ) u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (cctl),
    .sts       (csts),
    .pix_x     (w_px),
    .pix_y     (w_py),
    .swapped   (w_swapped),
    .ref_coord (w_ref),
    .den       (w_den),
    .col_a     (w_ca),
    .col_b     (w_cb),
    .color     (c_color)
  );

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_color_r;
  assign out_last        = out_last_r;

  // the color unit is never left running while requests are taken
  `ASSERT_IMP(a_idle_unit, st_r == T_IDLE, !csts.busy, "color unit busy while accepting requests")
  // a new result only appears from the compute state
  `ASSERT_IMP(a_out_src, $rose(out_valid_r), $past(st_r) == T_CALC, "result without computation")

endmodule

`default_nettype wire
